// ===== rtl/ort_pkg.sv =====
// ----------------------------------------------------------------------------
// ort_pkg
// Shared widths, codes and control-word types of the ordered record table.
// ----------------------------------------------------------------------------
package ort_pkg;

    localparam int CAPACITY     = 64;
    localparam int PAYLOAD_BITS = 32;

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int KIND_W  = 2;
    localparam int POS_W   = 7;
    localparam int KEY_W   = 64;
    localparam int PAY_W   = 32;
    localparam int STAT_W  = 2;
    localparam int TOTAL_W = 7;
    localparam int CMP_W   = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    localparam int S_DATA_W = 104;  // position, key, payload, pad
    localparam int M_DATA_W = 104;  // key, payload, total, pad
    localparam int UPC_W    = 5;

    typedef logic [UPC_W-1:0] upc_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_SEARCH = 2'd2,
        KIND_UNUSED = 2'd3
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_BAD  = 2'd1,
        STAT_FULL = 2'd2,
        STAT_MISS = 2'd3
    } stat_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_PTR_CNT,
        OP_PTR_POS,
        OP_PTR_ZERO,
        OP_RD_PREV,
        OP_WR_SHUP,
        OP_RD_CUR,
        OP_WR_SHDN,
        OP_WR_NEW,
        OP_CNT_DEC,
        OP_PTR_INC
    } dp_op_t;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_OK,
        RES_BAD,
        RES_FULL,
        RES_MISS,
        RES_FOUND
    } res_op_t;

    typedef enum logic [3:0] {
        COND_ALWAYS,
        COND_IN_VALID,
        COND_KIND_INS,
        COND_KIND_DEL,
        COND_KIND_SRCH,
        COND_FULL,
        COND_INS_BAD,
        COND_DEL_BAD,
        COND_INS_DONE,
        COND_SCAN_DONE,
        COND_MATCH,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        logic    accept;
        dp_op_t  op;
        res_op_t res;
        cond_t   cond;
        upc_t    tgt_true;
        upc_t    tgt_false;
    } ctl_word_t;

    typedef struct packed {
        logic in_valid;
        logic kind_ins;
        logic kind_del;
        logic kind_srch;
        logic full;
        logic ins_bad;
        logic del_bad;
        logic ins_done;
        logic scan_done;
        logic match;
        logic out_free;
    } dp_flags_t;

endpackage

// ===== rtl/ordered_record_table_core.sv =====
// ----------------------------------------------------------------------------
// One word in flight; the next is taken in the cycle after the reply is loaded.
// A shift step takes three microcode steps: loop test, read, write; a compare step: loop test, read, compare.
// Reset clears the entry count and the output valid; the record stores keep
// their contents and need no clearing pass.
// ----------------------------------------------------------------------------
// ordered_record_table_core
// Positional-insert/delete record list with key search, microcode controlled.
// ----------------------------------------------------------------------------
module ordered_record_table_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [6:0] position, [70:7] record_key, [102:71] record_payload, [103] zero
    input  logic [ort_pkg::S_DATA_W-1:0]    s_tdata,
    // [1:0] kind
    input  logic [ort_pkg::KIND_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [63:0] found_key, [95:64] found_payload, [102:96] entry_total, [103] zero
    output logic [ort_pkg::M_DATA_W-1:0]    m_tdata,
    // [1:0] status
    output logic [ort_pkg::STAT_W-1:0]      m_tuser
);
    import ort_pkg::*;

    ctl_word_t          ctl;
    dp_flags_t          flags;
    logic [KEY_W-1:0]   out_key;
    logic [PAY_W-1:0]   out_pay;
    logic [TOTAL_W-1:0] out_total;

    ort_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctl     (ctl)
    );

    ort_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .flags      (flags),
        .in_valid   (s_tvalid),
        .in_kind    (s_tuser),
        .in_pos     (s_tdata[POS_W-1:0]),
        .in_key     (s_tdata[POS_W+KEY_W-1:POS_W]),
        .in_pay     (s_tdata[POS_W+KEY_W+PAY_W-1:POS_W+KEY_W]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_key    (out_key),
        .out_pay    (out_pay),
        .out_total  (out_total)
    );

    assign s_tready = ctl.accept;
    assign m_tdata  = M_DATA_W'({out_total, out_pay, out_key});

endmodule

// ===== rtl/ort_useq.sv =====
// ----------------------------------------------------------------------------
// ort_useq
// Microcode sequencer: program ROM, step counter and two-way conditional jump.
// ----------------------------------------------------------------------------
module ort_useq (
    input  logic              aclk,
    input  logic              aresetn,
    input  ort_pkg::dp_flags_t flags,
    output ort_pkg::ctl_word_t ctl
);
    import ort_pkg::*;

    localparam upc_t U_IDLE      = 5'd0;
    localparam upc_t U_DISP_INS  = 5'd1;
    localparam upc_t U_DISP_DEL  = 5'd2;
    localparam upc_t U_DISP_SRCH = 5'd3;
    localparam upc_t U_INS_FULL  = 5'd4;
    localparam upc_t U_INS_CHK   = 5'd5;
    localparam upc_t U_INS_LOOP  = 5'd6;
    localparam upc_t U_INS_RD    = 5'd7;
    localparam upc_t U_INS_WR    = 5'd8;
    localparam upc_t U_INS_NEW   = 5'd9;
    localparam upc_t U_DEL_CHK   = 5'd10;
    localparam upc_t U_DEL_LOOP  = 5'd11;
    localparam upc_t U_DEL_RD    = 5'd12;
    localparam upc_t U_DEL_WR    = 5'd13;
    localparam upc_t U_DEL_DEC   = 5'd14;
    localparam upc_t U_SRCH_INIT = 5'd15;
    localparam upc_t U_SRCH_LOOP = 5'd16;
    localparam upc_t U_SRCH_RD   = 5'd17;
    localparam upc_t U_SRCH_CMP  = 5'd18;
    localparam upc_t U_EM_FOUND  = 5'd19;
    localparam upc_t U_EM_OK     = 5'd20;
    localparam upc_t U_EM_MISS   = 5'd21;
    localparam upc_t U_EM_BAD    = 5'd22;
    localparam upc_t U_EM_FULL   = 5'd23;

    upc_t upc_reg;
    upc_t upc_next;
    logic cond_hit;

    function automatic ctl_word_t uw(logic acc, dp_op_t op, res_op_t res, cond_t c,
                                     upc_t t, upc_t f);
        ctl_word_t w;
        w.accept    = acc;
        w.op        = op;
        w.res       = res;
        w.cond      = c;
        w.tgt_true  = t;
        w.tgt_false = f;
        return w;
    endfunction

    function automatic ctl_word_t rom(upc_t pc);
        ctl_word_t w;
        unique case (pc)
            U_IDLE:      w = uw(1'b1, OP_NONE, RES_NONE, COND_IN_VALID, U_DISP_INS, U_IDLE);
            U_DISP_INS:  w = uw(1'b0, OP_NONE, RES_NONE, COND_KIND_INS, U_INS_FULL, U_DISP_DEL);
            U_DISP_DEL:  w = uw(1'b0, OP_NONE, RES_NONE, COND_KIND_DEL, U_DEL_CHK, U_DISP_SRCH);
            U_DISP_SRCH: w = uw(1'b0, OP_NONE, RES_NONE, COND_KIND_SRCH, U_SRCH_INIT,
                                U_EM_BAD);
            U_INS_FULL:  w = uw(1'b0, OP_NONE, RES_NONE, COND_FULL, U_EM_FULL, U_INS_CHK);
            U_INS_CHK:   w = uw(1'b0, OP_PTR_CNT, RES_NONE, COND_INS_BAD, U_EM_BAD,
                                U_INS_LOOP);
            U_INS_LOOP:  w = uw(1'b0, OP_NONE, RES_NONE, COND_INS_DONE, U_INS_NEW, U_INS_RD);
            U_INS_RD:    w = uw(1'b0, OP_RD_PREV, RES_NONE, COND_ALWAYS, U_INS_WR, U_INS_WR);
            U_INS_WR:    w = uw(1'b0, OP_WR_SHUP, RES_NONE, COND_ALWAYS, U_INS_LOOP,
                                U_INS_LOOP);
            U_INS_NEW:   w = uw(1'b0, OP_WR_NEW, RES_NONE, COND_ALWAYS, U_EM_OK, U_EM_OK);
            U_DEL_CHK:   w = uw(1'b0, OP_PTR_POS, RES_NONE, COND_DEL_BAD, U_EM_BAD,
                                U_DEL_LOOP);
            U_DEL_LOOP:  w = uw(1'b0, OP_NONE, RES_NONE, COND_SCAN_DONE, U_DEL_DEC, U_DEL_RD);
            U_DEL_RD:    w = uw(1'b0, OP_RD_CUR, RES_NONE, COND_ALWAYS, U_DEL_WR, U_DEL_WR);
            U_DEL_WR:    w = uw(1'b0, OP_WR_SHDN, RES_NONE, COND_ALWAYS, U_DEL_LOOP,
                                U_DEL_LOOP);
            U_DEL_DEC:   w = uw(1'b0, OP_CNT_DEC, RES_NONE, COND_ALWAYS, U_EM_OK, U_EM_OK);
            U_SRCH_INIT: w = uw(1'b0, OP_PTR_ZERO, RES_NONE, COND_ALWAYS, U_SRCH_LOOP,
                                U_SRCH_LOOP);
            U_SRCH_LOOP: w = uw(1'b0, OP_NONE, RES_NONE, COND_SCAN_DONE, U_EM_MISS,
                                U_SRCH_RD);
            U_SRCH_RD:   w = uw(1'b0, OP_RD_CUR, RES_NONE, COND_ALWAYS, U_SRCH_CMP,
                                U_SRCH_CMP);
            U_SRCH_CMP:  w = uw(1'b0, OP_PTR_INC, RES_NONE, COND_MATCH, U_EM_FOUND,
                                U_SRCH_LOOP);
            U_EM_FOUND:  w = uw(1'b0, OP_NONE, RES_FOUND, COND_OUT_FREE, U_IDLE, U_EM_FOUND);
            U_EM_OK:     w = uw(1'b0, OP_NONE, RES_OK, COND_OUT_FREE, U_IDLE, U_EM_OK);
            U_EM_MISS:   w = uw(1'b0, OP_NONE, RES_MISS, COND_OUT_FREE, U_IDLE, U_EM_MISS);
            U_EM_BAD:    w = uw(1'b0, OP_NONE, RES_BAD, COND_OUT_FREE, U_IDLE, U_EM_BAD);
            U_EM_FULL:   w = uw(1'b0, OP_NONE, RES_FULL, COND_OUT_FREE, U_IDLE, U_EM_FULL);
            default:     w = uw(1'b0, OP_NONE, RES_NONE, COND_ALWAYS, U_IDLE, U_IDLE);
        endcase
        return w;
    endfunction

    assign ctl = rom(upc_reg);

    always_comb begin
        unique case (ctl.cond)
            COND_ALWAYS:    cond_hit = 1'b1;
            COND_IN_VALID:  cond_hit = flags.in_valid;
            COND_KIND_INS:  cond_hit = flags.kind_ins;
            COND_KIND_DEL:  cond_hit = flags.kind_del;
            COND_KIND_SRCH: cond_hit = flags.kind_srch;
            COND_FULL:      cond_hit = flags.full;
            COND_INS_BAD:   cond_hit = flags.ins_bad;
            COND_DEL_BAD:   cond_hit = flags.del_bad;
            COND_INS_DONE:  cond_hit = flags.ins_done;
            COND_SCAN_DONE: cond_hit = flags.scan_done;
            COND_MATCH:     cond_hit = flags.match;
            COND_OUT_FREE:  cond_hit = flags.out_free;
            default:        cond_hit = 1'b1;
        endcase
        upc_next = cond_hit ? ctl.tgt_true : ctl.tgt_false;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= U_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

// ===== rtl/ort_dpath.sv =====
// ----------------------------------------------------------------------------
// ort_dpath
// Datapath: record memory, word pointer, entry count, condition flags and
// the output word register.
// ----------------------------------------------------------------------------
module ort_dpath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ort_pkg::ctl_word_t            ctl,
    output ort_pkg::dp_flags_t            flags,
    input  logic                          in_valid,
    input  logic [ort_pkg::KIND_W-1:0]    in_kind,
    input  logic [ort_pkg::POS_W-1:0]     in_pos,
    input  logic [ort_pkg::KEY_W-1:0]     in_key,
    input  logic [ort_pkg::PAY_W-1:0]     in_pay,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ort_pkg::STAT_W-1:0]    out_status,
    output logic [ort_pkg::KEY_W-1:0]     out_key,
    output logic [ort_pkg::PAY_W-1:0]     out_pay,
    output logic [ort_pkg::TOTAL_W-1:0]   out_total
);
    import ort_pkg::*;

    logic [KEY_W-1:0]        key_mem [CAPACITY];
    logic [PAYLOAD_BITS-1:0] pay_mem [CAPACITY];

    logic [KIND_W-1:0]       kind_reg;
    logic [POS_W-1:0]        pos_reg;
    logic [KEY_W-1:0]        key_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic [CNT_W-1:0]        ptr_reg;
    logic [CNT_W-1:0]        ptr_next;
    logic [KEY_W-1:0]        rd_key_reg;
    logic [PAYLOAD_BITS-1:0] rd_pay_reg;

    logic                    m_valid_reg;
    logic [STAT_W-1:0]       m_status_reg;
    logic [KEY_W-1:0]        m_key_reg;
    logic [PAY_W-1:0]        m_pay_reg;
    logic [TOTAL_W-1:0]      m_total_reg;

    logic                    load_in;
    logic                    load_res;
    logic                    out_free;
    logic [CNT_W-1:0]        ptr_dec;
    logic [POS_W-1:0]        pos_dec;
    logic [CMP_W-1:0]        pos_x;
    logic [CMP_W-1:0]        cnt_x;
    logic [CMP_W-1:0]        ptr_x;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_idx;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_idx;
    logic [KEY_W-1:0]        wr_key;
    logic [PAYLOAD_BITS-1:0] wr_pay;
    stat_t                   res_status;

    assign load_in  = ctl.accept && in_valid;
    assign out_free = !m_valid_reg || out_ready;
    assign load_res = (ctl.res != RES_NONE) && out_free;
    assign ptr_dec  = ptr_reg - 1'b1;
    assign pos_dec  = pos_reg - 1'b1;
    assign pos_x    = CMP_W'(pos_reg);
    assign cnt_x    = CMP_W'(cnt_reg);
    assign ptr_x    = CMP_W'(ptr_reg);

    always_comb begin
        flags.in_valid  = in_valid;
        flags.kind_ins  = kind_reg == KIND_INSERT;
        flags.kind_del  = kind_reg == KIND_DELETE;
        flags.kind_srch = kind_reg == KIND_SEARCH;
        flags.full      = cnt_reg == CNT_W'(CAPACITY);
        flags.ins_bad   = (pos_reg == '0) || (pos_x > cnt_x + 1'b1);
        flags.del_bad   = (pos_reg == '0) || (pos_x > cnt_x);
        flags.ins_done  = ptr_x < pos_x;
        flags.scan_done = ptr_reg >= cnt_reg;
        flags.match     = rd_key_reg == key_reg;
        flags.out_free  = out_free;
    end

    // memory port control
    always_comb begin
        rd_en  = 1'b0;
        rd_idx = ptr_reg[IDX_W-1:0];
        wr_en  = 1'b0;
        wr_idx = ptr_reg[IDX_W-1:0];
        wr_key = rd_key_reg;
        wr_pay = rd_pay_reg;
        unique case (ctl.op)
            OP_RD_PREV: begin
                rd_en  = 1'b1;
                rd_idx = ptr_dec[IDX_W-1:0];
            end
            OP_RD_CUR: begin
                rd_en = 1'b1;
            end
            OP_WR_SHUP: begin
                wr_en = 1'b1;
            end
            OP_WR_SHDN: begin
                wr_en  = 1'b1;
                wr_idx = ptr_dec[IDX_W-1:0];
            end
            OP_WR_NEW: begin
                wr_en  = 1'b1;
                wr_idx = pos_dec[IDX_W-1:0];
                wr_key = key_reg;
                wr_pay = pay_reg;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        ptr_next = ptr_reg;
        cnt_next = cnt_reg;
        unique case (ctl.op)
            OP_PTR_CNT:  ptr_next = cnt_reg;
            OP_PTR_POS:  ptr_next = CNT_W'(pos_reg);
            OP_PTR_ZERO: ptr_next = '0;
            OP_WR_SHUP:  ptr_next = ptr_dec;
            OP_WR_SHDN:  ptr_next = ptr_reg + 1'b1;
            OP_PTR_INC:  ptr_next = ptr_reg + 1'b1;
            OP_WR_NEW:   cnt_next = cnt_reg + 1'b1;
            OP_CNT_DEC:  cnt_next = cnt_reg - 1'b1;
            default: begin
            end
        endcase
    end

    always_comb begin
        unique case (ctl.res)
            RES_BAD:  res_status = STAT_BAD;
            RES_FULL: res_status = STAT_FULL;
            RES_MISS: res_status = STAT_MISS;
            default:  res_status = STAT_OK;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_idx] <= wr_key;
            pay_mem[wr_idx] <= wr_pay;
        end
        if (rd_en) begin
            rd_key_reg <= key_mem[rd_idx];
            rd_pay_reg <= pay_mem[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (load_res) begin
                m_valid_reg <= 1'b1;
            end else if (out_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg <= ptr_next;
        if (load_in) begin
            kind_reg <= in_kind;
            pos_reg  <= in_pos;
            key_reg  <= in_key;
            pay_reg  <= in_pay[PAYLOAD_BITS-1:0];
        end
        if (load_res) begin
            m_status_reg <= res_status;
            m_total_reg  <= TOTAL_W'(cnt_reg);
            if (ctl.res == RES_FOUND) begin
                m_key_reg <= rd_key_reg;
                m_pay_reg <= PAY_W'(rd_pay_reg);
            end else begin
                m_key_reg <= '0;
                m_pay_reg <= '0;
            end
        end
    end

    assign out_valid  = m_valid_reg;
    assign out_status = m_status_reg;
    assign out_key    = m_key_reg;
    assign out_pay    = m_pay_reg;
    assign out_total  = m_total_reg;

endmodule

// ===== test/ordered_record_table_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_record_table_core_tb
// Drives positional insert, delete and key search words into the record table
// and checks every reply against a cycle-free table model kept in the bench.
// A directed opener hits the edge cases, then random stretches fill, churn and
// drain the table, with random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module ordered_record_table_core_tb;
    import ort_pkg::*;

    localparam int MAX_ENTRIES  = 64;
    localparam int RANDOM_WORDS = 1150;
    localparam int HOLD_AFTER   = 400;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 250;

    typedef struct {
        kind_t              kind;
        logic [POS_W-1:0]   pos;
        logic signed [63:0] key;
        logic [31:0]        pay;
    } table_op_t;

    typedef struct {
        stat_t              status;
        logic signed [63:0] key;
        logic [31:0]        pay;
        logic [TOTAL_W-1:0] total;
    } reply_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata = '0;
    logic [KIND_W-1:0]    s_tuser = KIND_INSERT;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic [STAT_W-1:0]    m_tuser;

    ordered_record_table_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // bench copy of the table
    logic signed [63:0] tbl_key [0:MAX_ENTRIES-1];
    logic [31:0]        tbl_pay [0:MAX_ENTRIES-1];
    int                 tbl_count = 0;

    table_op_t          pending_ops [$];
    reply_t             expected_replies [$];
    logic signed [63:0] gen_keys [$];    // keys as the generator expects them to sit

    table_op_t cur_op;
    int        err_count = 0;
    int        ops_taken = 0;
    int        total_ops = 0;
    int        replies_seen = 0;
    int        send_gap = 0;
    int        recv_gap = 0;
    bit        send_quiet = 1'b0;
    bit        recv_quiet = 1'b0;
    int        hold_left = 0;
    bit        hold_fired = 1'b0;
    wire       hold_active = (hold_left != 0);

    int kind_hits [0:3];
    int stat_hits [0:3];
    int peak_count = 0;

    function automatic int draw_gap(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 5);
    endfunction

    // apply one accepted word to the bench table and queue its reply
    task automatic apply_table_op(input table_op_t op);
        reply_t r;
        int     j;
        r.status = STAT_OK;
        r.key    = '0;
        r.pay    = '0;
        case (op.kind)
            KIND_INSERT: begin
                if (tbl_count >= MAX_ENTRIES) begin
                    r.status = STAT_FULL;
                end else if (op.pos < 1 || op.pos > tbl_count + 1) begin
                    r.status = STAT_BAD;
                end else begin
                    for (j = tbl_count; j >= op.pos; j--) begin
                        tbl_key[j] = tbl_key[j-1];
                        tbl_pay[j] = tbl_pay[j-1];
                    end
                    tbl_key[op.pos-1] = op.key;
                    tbl_pay[op.pos-1] = op.pay;
                    tbl_count++;
                end
            end
            KIND_DELETE: begin
                if (tbl_count == 0 || op.pos < 1 || op.pos > tbl_count) begin
                    r.status = STAT_BAD;
                end else begin
                    for (j = op.pos; j < tbl_count; j++) begin
                        tbl_key[j-1] = tbl_key[j];
                        tbl_pay[j-1] = tbl_pay[j];
                    end
                    tbl_count--;
                end
            end
            KIND_SEARCH: begin
                r.status = STAT_MISS;
                for (j = 0; j < tbl_count; j++) begin
                    if (tbl_key[j] == op.key) begin
                        r.status = STAT_OK;
                        r.key    = tbl_key[j];
                        r.pay    = tbl_pay[j];
                        break;
                    end
                end
            end
            default: r.status = STAT_BAD;
        endcase
        r.total = tbl_count[TOTAL_W-1:0];
        kind_hits[op.kind]++;
        stat_hits[r.status]++;
        if (tbl_count > peak_count) peak_count = tbl_count;
        expected_replies.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH reply %0d %s: got %h, expected %h",
                 replies_seen, what, got, want);
        err_count++;
    endtask

    // queue a word and keep the generator's view of the keys in step
    task automatic add_op(input kind_t kind, input int pos, input logic signed [63:0] key,
                          input logic [31:0] pay);
        table_op_t op;
        int        n;
        op.kind = kind;
        op.pos  = pos[POS_W-1:0];
        op.key  = key;
        op.pay  = pay;
        n = gen_keys.size();
        if (kind == KIND_INSERT && n < MAX_ENTRIES && op.pos >= 1 && op.pos <= n + 1)
            gen_keys.insert(op.pos - 1, key);
        else if (kind == KIND_DELETE && op.pos >= 1 && op.pos <= n)
            gen_keys.delete(op.pos - 1);
        pending_ops.push_back(op);
    endtask

    function automatic logic signed [63:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return 64'sh8000_0000_0000_0000;
            1:       return 64'sh7fff_ffff_ffff_ffff;
            2:       return -64'sd1;
            3, 4, 5: return $urandom_range(0, 7);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic int good_pos(input int lim);
        case ($urandom_range(0, 3))
            0:       return 1;
            1:       return lim;
            default: return $urandom_range(1, lim);
        endcase
    endfunction

    function automatic int bad_pos(input int lim);
        if (lim >= 127 || $urandom_range(0, 2) == 0) return 0;
        return $urandom_range(lim + 1, 127);
    endfunction

    task automatic build_random_ops();
        int  i;
        int  seg_left;
        int  mode;
        int  n;
        int  r;
        int  ins_w;
        int  del_w;
        seg_left = 0;
        mode     = 0;
        for (i = 0; i < RANDOM_WORDS; i++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(80, 150);
                mode = (mode + 1) % 3;
            end
            seg_left--;
            // mode 0 drains, 1 fills, 2 churns
            ins_w = (mode == 1) ? 70 : (mode == 0) ? 10 : 35;
            del_w = (mode == 0) ? 70 : (mode == 1) ? 10 : 30;
            n = gen_keys.size();
            r = $urandom_range(0, 99);
            if (r < ins_w) begin
                add_op(KIND_INSERT,
                       ($urandom_range(0, 6) == 0) ? bad_pos(n + 1) : good_pos(n + 1),
                       pick_key(), $urandom);
            end else if (r < ins_w + del_w) begin
                add_op(KIND_DELETE,
                       (n == 0 || $urandom_range(0, 6) == 0) ? bad_pos(n) : good_pos(n),
                       pick_key(), $urandom);
            end else if (r < 95) begin
                add_op(KIND_SEARCH, $urandom_range(0, 127),
                       (n > 0 && $urandom_range(0, 4) < 3) ?
                           gen_keys[$urandom_range(0, n - 1)] : pick_key(),
                       $urandom);
            end else begin
                add_op(KIND_UNUSED, $urandom_range(0, 127), pick_key(), $urandom);
            end
        end
    endtask

    // driver
    always @(posedge aclk) begin : drive_proc
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                apply_table_op(cur_op);
                ops_taken <= ops_taken + 1;
                send_gap = draw_gap(send_quiet);
                if ($urandom_range(0, 63) == 0) send_quiet = !send_quiet;
            end
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_ops.size() != 0) begin
                cur_op = pending_ops.pop_front();
                s_tdata  <= {1'b0, cur_op.pay, cur_op.key, cur_op.pos};
                s_tuser  <= cur_op.kind;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // long output stall once the run is under way
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left  <= 0;
            hold_fired <= 1'b0;
        end else if (!hold_fired && ops_taken >= HOLD_AFTER) begin
            hold_left  <= HOLD_CYCLES;
            hold_fired <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge aclk) begin : watch_proc
        reply_t got;
        reply_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.status = stat_t'(m_tuser);
                got.key    = m_tdata[63:0];
                got.pay    = m_tdata[95:64];
                got.total  = m_tdata[102:96];
                if (expected_replies.size() == 0) begin
                    report_mismatch("unexpected word, status", got.status, '0);
                end else begin
                    want = expected_replies.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.key !== want.key)
                        report_mismatch("found_key", got.key, want.key);
                    if (got.pay !== want.pay)
                        report_mismatch("found_payload", got.pay, want.pay);
                    if (got.total !== want.total)
                        report_mismatch("entry_total", got.total, want.total);
                end
                replies_seen++;
                recv_gap = draw_gap(recv_quiet);
                if ($urandom_range(0, 63) == 0) recv_quiet = !recv_quiet;
            end
            if (hold_active) begin
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        for (int k = 0; k < 4; k++) begin
            kind_hits[k] = 0;
            stat_hits[k] = 0;
        end
        // directed opener
        add_op(KIND_SEARCH, 1, 64'sd5, 32'h0);                           // empty search
        add_op(KIND_DELETE, 1, 64'sd0, 32'h0);                           // empty delete
        add_op(KIND_INSERT, 0, 64'sd9, 32'h1);
        add_op(KIND_INSERT, 2, 64'sd9, 32'h1);
        add_op(KIND_INSERT, 1, 64'sh8000_0000_0000_0000, 32'h0000_0000);
        add_op(KIND_INSERT, 2, 64'sh7fff_ffff_ffff_ffff, 32'hffff_ffff);
        add_op(KIND_INSERT, 1, -64'sd1, 32'ha5a5_a5a5);
        add_op(KIND_INSERT, 127, 64'sd3, 32'h3);
        add_op(KIND_INSERT, 3, 64'sd0, 32'h0000_0001);
        add_op(KIND_INSERT, 5, -64'sd1, 32'h0000_0002);                  // duplicate key
        add_op(KIND_SEARCH, 0, -64'sd1, 32'h0);                          // first match wins
        add_op(KIND_SEARCH, 0, 64'sh7fff_ffff_ffff_ffff, 32'h0);
        add_op(KIND_SEARCH, 0, 64'sh8000_0000_0000_0000, 32'h0);
        add_op(KIND_SEARCH, 0, 64'sd42, 32'h0);
        add_op(KIND_DELETE, 0, 64'sd0, 32'h0);
        add_op(KIND_DELETE, 6, 64'sd0, 32'h0);
        add_op(KIND_DELETE, 5, 64'sd0, 32'h0);                           // last entry
        add_op(KIND_DELETE, 1, 64'sd0, 32'h0);
        add_op(KIND_SEARCH, 0, -64'sd1, 32'h0);
        add_op(KIND_UNUSED, 1, 64'sd0, 32'h5a5a_5a5a);
        add_op(KIND_SEARCH, 0, 64'sh8000_0000_0000_0000, 32'h0);
        add_op(KIND_DELETE, 2, 64'sd0, 32'h0);
        add_op(KIND_SEARCH, 0, 64'sh7fff_ffff_ffff_ffff, 32'h0);
        add_op(KIND_DELETE, 127, 64'sd0, 32'h0);
        build_random_ops();
        total_ops = pending_ops.size();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (ops_taken < total_ops) @(posedge aclk);
        while (expected_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d words: %0d inserts, %0d deletes, %0d searches, %0d unused kind",
                 ops_taken, kind_hits[KIND_INSERT], kind_hits[KIND_DELETE],
                 kind_hits[KIND_SEARCH], kind_hits[KIND_UNUSED]);
        $display("Replies ok/bad/full/miss %0d/%0d/%0d/%0d, peak %0d entries, %0d mismatches",
                 stat_hits[STAT_OK], stat_hits[STAT_BAD], stat_hits[STAT_FULL],
                 stat_hits[STAT_MISS], peak_count, err_count);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timeout with %0d replies still outstanding", expected_replies.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
